// ----- rtl/core/rts_pkg.sv -----
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types, codes and child tables of the refinement transform stack.
// ----------------------------------------------------------------------------
package rts_pkg;

    // Field widths fixed by the interface
    localparam int PATH_W  = 46;
    localparam int CHILD_W = 4;
    localparam int MODE_W  = 2;
    localparam int FAULT_W = 2;
    localparam int OUT_W   = 32;
    localparam int LEVEL_W = 4;

    // Defaults for the top level parameters
    localparam int MAX_LEVEL_DEF = 15;
    localparam int FRAC_BITS_DEF = 30;

    // Identity child and its path digit
    localparam logic [CHILD_W-1:0] CHILD_IDENTITY = 4'd8;
    localparam logic [CHILD_W-1:0] DIGIT_IDENTITY = 4'd9;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd3;

    // Fault codes
    localparam logic [FAULT_W-1:0] FAULT_OK       = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_TOO_DEEP = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_EMPTY    = 2'd2;

    // Factor applied to a parent scale: 1, 1/2, -1/2 or 0
    typedef enum logic [1:0] {
        FACT_ONE,
        FACT_HALF,
        FACT_NHALF,
        FACT_ZERO
    } factor_t;

    // Factors of one child: x scale, y scale, x offset, y offset
    typedef struct packed {
        factor_t sx;
        factor_t sy;
        factor_t ox;
        factor_t oy;
    } child_row_t;

    localparam child_row_t IDENT_ROW = '{FACT_ONE, FACT_ONE, FACT_ZERO, FACT_ZERO};

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SHOW,
        S_DECODE,
        S_SET_RD
    } state_t;

    // Input request
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [CHILD_W-1:0] child;
        logic [PATH_W-1:0]  path_in;
    } req_t;

    // Result
    typedef struct packed {
        logic signed [OUT_W-1:0] scale_x;
        logic signed [OUT_W-1:0] scale_y;
        logic signed [OUT_W-1:0] offset_x;
        logic signed [OUT_W-1:0] offset_y;
        logic [LEVEL_W-1:0]      level;
        logic [PATH_W-1:0]       path_out;
        logic [FAULT_W-1:0]      fault;
    } rsp_t;

    // Child table lookup; children above seven (quad) or above three (triangle) fall to the identity row
    function automatic child_row_t child_row(input logic is_tri,
                                             input logic [CHILD_W-1:0] child);
        child_row_t row;
        begin
            row = IDENT_ROW;
            if (is_tri)
            begin
                case (child)
                    4'd0:    row = '{FACT_HALF,  FACT_HALF,  FACT_NHALF, FACT_NHALF};
                    4'd1:    row = '{FACT_HALF,  FACT_HALF,  FACT_HALF,  FACT_NHALF};
                    4'd2:    row = '{FACT_HALF,  FACT_HALF,  FACT_NHALF, FACT_HALF};
                    4'd3:    row = '{FACT_NHALF, FACT_NHALF, FACT_NHALF, FACT_NHALF};
                    default: row = IDENT_ROW;
                endcase
            end
            else
            begin
                case (child)
                    4'd0:    row = '{FACT_HALF, FACT_HALF, FACT_NHALF, FACT_NHALF};
                    4'd1:    row = '{FACT_HALF, FACT_HALF, FACT_HALF,  FACT_NHALF};
                    4'd2:    row = '{FACT_HALF, FACT_HALF, FACT_HALF,  FACT_HALF};
                    4'd3:    row = '{FACT_HALF, FACT_HALF, FACT_NHALF, FACT_HALF};
                    4'd4:    row = '{FACT_ONE,  FACT_HALF, FACT_ZERO,  FACT_NHALF};
                    4'd5:    row = '{FACT_ONE,  FACT_HALF, FACT_ZERO,  FACT_HALF};
                    4'd6:    row = '{FACT_HALF, FACT_ONE,  FACT_NHALF, FACT_ZERO};
                    4'd7:    row = '{FACT_HALF, FACT_ONE,  FACT_HALF,  FACT_ZERO};
                    default: row = IDENT_ROW;
                endcase
            end
            return row;
        end
    endfunction

endpackage

// ----- rtl/core/rts_ram.sv -----
// ----------------------------------------------------------------------------
// rts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/rts_compose.sv -----
// ----------------------------------------------------------------------------
// rts_compose
// Composes the parent transform with the factors of one child map.
// ----------------------------------------------------------------------------
module rts_compose #(
    parameter int FRAC_BITS = rts_pkg::FRAC_BITS_DEF,
    parameter int W         = FRAC_BITS + 2
) (
    input  logic [4*W-1:0]         src,
    input  rts_pkg::child_row_t    row,
    output logic [4*W-1:0]         dst
);
    import rts_pkg::*;

    logic signed [W-1:0] sx;
    logic signed [W-1:0] sy;
    logic signed [W-1:0] ox;
    logic signed [W-1:0] oy;
    logic signed [W-1:0] nsx;
    logic signed [W-1:0] nsy;
    logic signed [W-1:0] nox;
    logic signed [W-1:0] noy;

    // Times 1, 1/2 or -1/2 (halving rounds toward minus infinity), or 0
    function automatic logic signed [W-1:0] apply(input logic signed [W-1:0] v,
                                                  input factor_t f);
        logic signed [W-1:0] neg;
        begin
            neg = -v;
            case (f)
                FACT_ONE:   return v;
                FACT_HALF:  return v >>> 1;
                FACT_NHALF: return neg >>> 1;
                default:    return '0;
            endcase
        end
    endfunction

    assign {sx, sy, ox, oy} = src;

    // Offsets move by the parent scale times the child factor
    always_comb
    begin
        nsx = apply(sx, row.sx);
        nsy = apply(sy, row.sy);
        nox = apply(sx, row.ox) + ox;
        noy = apply(sy, row.oy) + oy;
    end

    assign dst = {nsx, nsy, nox, noy};

endmodule

// ----- rtl/core/refinement_transform_stack.sv -----
// ----------------------------------------------------------------------------
// refinement_transform_stack
// Stack of axis-aligned scale/offset transforms for nested element refinement.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: raise start with req; it is taken at a clock edge where
//   busy is low. Modes: push child, pop, set from a base-8 path, reset.
//   Result channel: done is high for exactly one cycle with res holding the
//   top transform (Q2.30), depth, path and fault; the receiver cannot stall,
//   so res must be captured in that cycle.
//   Configuration: cfg_data selects the triangle (1) or quad (0) child table;
//   cfg_ready is always high, write only while the block is idle.
// Sequence
//   Push, pop and reset: the result is registered from the S_PUSH or S_SHOW
//   state, and a new request can be taken in the cycle done is shown.
//   Set: S_DECODE stores one path digit per step, then each digit is pushed
//   through S_SET_RD and S_PUSH; an empty or too-deep path goes to S_SHOW.
//   Each push is a registered read of the top entry from the transform RAM
//   followed by a compose and write of the next entry.
// Reset
//   Level, path and table select clear; entry zero is the fixed identity and
//   is never held in the RAM, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module refinement_transform_stack #(
    parameter int MAX_LEVEL = rts_pkg::MAX_LEVEL_DEF,
    parameter int FRAC_BITS = rts_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rts_pkg::req_t req,
    output logic          done,
    output rts_pkg::rsp_t res,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);
    import rts_pkg::*;

    localparam int W     = FRAC_BITS + 2;
    localparam int XW    = 4 * W;
    localparam int DEPTH = MAX_LEVEL + 1;
    localparam int LW    = $clog2(DEPTH);

    localparam logic [LW-1:0]       LEVEL_MAX = LW'(MAX_LEVEL);
    localparam logic signed [W-1:0] ONE_FX    = W'(1) <<< FRAC_BITS;
    localparam logic [XW-1:0]       IDENT_XF  = {ONE_FX, ONE_FX, {W{1'b0}}, {W{1'b0}}};

    state_t              state_reg, state_next;
    logic [LW-1:0]       level_reg, level_next;
    logic [PATH_W-1:0]   path_reg, path_next;
    logic                element_is_triangle_reg;
    logic [LW-1:0]       cnt_reg, cnt_next;
    logic [FAULT_W-1:0]  fault_reg, fault_next;
    logic                done_reg, done_next;
    logic [CHILD_W-1:0]  child_reg, child_next;
    logic [PATH_W-1:0]   idx_reg, idx_next;
    rsp_t                res_reg, res_next;
    logic [2:0]          digit_reg [DEPTH];

    logic                accept;
    logic                digit_we;
    logic [PATH_W-1:0]   idx_dec;
    logic                ram_we;
    logic                ram_re;
    logic [LW-1:0]       ram_waddr;
    logic [LW-1:0]       ram_raddr;
    logic [XW-1:0]       ram_rdata;
    logic [XW-1:0]       top_xf;
    logic [XW-1:0]       new_xf;
    child_row_t          row;
    logic [CHILD_W-1:0]  path_digit;
    logic [PATH_W-1:0]   pushed_path;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign res       = res_reg;

    // Transform store, entries one to MAX_LEVEL
    rts_ram #(
        .WIDTH (XW),
        .DEPTH (DEPTH),
        .AW    (LW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (new_xf),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Top entry: level zero is the fixed identity
    assign top_xf = (level_reg == '0) ? IDENT_XF : ram_rdata;
    assign row    = child_row(element_is_triangle_reg, child_reg);

    rts_compose #(
        .FRAC_BITS (FRAC_BITS),
        .W         (W)
    ) u_compose (
        .src (top_xf),
        .row (row),
        .dst (new_xf)
    );

    // Path after a push: append child+1; the identity child and any above it give digit nine
    assign path_digit  = (child_reg > CHILD_IDENTITY) ? DIGIT_IDENTITY : child_reg + 1'b1;
    assign pushed_path = {path_reg[PATH_W-4:0], 3'b000} + PATH_W'(path_digit);

    // One path digit per decode step
    assign idx_dec = idx_reg - 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.mode)
                        MODE_PUSH: state_next = (level_reg == LEVEL_MAX) ? S_SHOW : S_PUSH;
                        MODE_SET:  state_next = S_DECODE;
                        default:   state_next = S_SHOW;
                    endcase
                end
            end
            S_PUSH:
            begin
                state_next = (cnt_reg == '0) ? S_IDLE : S_SET_RD;
            end
            S_SHOW:
            begin
                state_next = S_IDLE;
            end
            S_DECODE:
            begin
                if (idx_reg == '0)
                begin
                    state_next = (cnt_reg == '0) ? S_SHOW : S_SET_RD;
                end
                else if (cnt_reg == LEVEL_MAX)
                begin
                    state_next = S_SHOW;
                end
            end
            S_SET_RD:
            begin
                state_next = S_PUSH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        level_next = level_reg;
        path_next  = path_reg;
        cnt_next   = cnt_reg;
        fault_next = fault_reg;
        done_next  = 1'b0;
        child_next = child_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        digit_we   = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = level_reg + 1'b1;
        ram_raddr  = level_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fault_next = FAULT_OK;
                    child_next = req.child;
                    cnt_next   = '0;
                    case (req.mode)
                        MODE_PUSH:
                        begin
                            ram_re = 1'b1;
                            if (level_reg == LEVEL_MAX)
                            begin
                                fault_next = FAULT_TOO_DEEP;
                            end
                        end
                        MODE_POP:
                        begin
                            if (level_reg == '0)
                            begin
                                fault_next = FAULT_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = level_reg - 1'b1;
                                level_next = level_reg - 1'b1;
                                path_next  = (path_reg - 1'b1) >> 3;
                            end
                        end
                        MODE_SET:
                        begin
                            level_next = '0;
                            path_next  = '0;
                            idx_next   = req.path_in;
                        end
                        default:
                        begin
                            level_next = '0;
                            path_next  = '0;
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                ram_we     = 1'b1;
                level_next = level_reg + 1'b1;
                path_next  = pushed_path;
                if (cnt_reg == '0)
                begin
                    done_next         = 1'b1;
                    res_next.scale_x  = OUT_W'($signed(new_xf[4*W-1:3*W]));
                    res_next.scale_y  = OUT_W'($signed(new_xf[3*W-1:2*W]));
                    res_next.offset_x = OUT_W'($signed(new_xf[2*W-1:W]));
                    res_next.offset_y = OUT_W'($signed(new_xf[W-1:0]));
                    res_next.level    = LEVEL_W'(level_reg + 1'b1);
                    res_next.path_out = pushed_path;
                    res_next.fault    = fault_reg;
                end
            end
            S_SHOW:
            begin
                done_next         = 1'b1;
                res_next.scale_x  = OUT_W'($signed(top_xf[4*W-1:3*W]));
                res_next.scale_y  = OUT_W'($signed(top_xf[3*W-1:2*W]));
                res_next.offset_x = OUT_W'($signed(top_xf[2*W-1:W]));
                res_next.offset_y = OUT_W'($signed(top_xf[W-1:0]));
                res_next.level    = LEVEL_W'(level_reg);
                res_next.path_out = path_reg;
                res_next.fault    = fault_reg;
            end
            S_DECODE:
            begin
                if (idx_reg != '0)
                begin
                    if (cnt_reg == LEVEL_MAX)
                    begin
                        // path longer than the stack: leave it reset
                        fault_next = FAULT_TOO_DEEP;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        digit_we = 1'b1;
                        idx_next = idx_dec >> 3;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_SET_RD:
            begin
                // most significant digit is pushed first
                ram_re     = 1'b1;
                child_next = {1'b0, digit_reg[cnt_reg - 1'b1]};
                cnt_next   = cnt_reg - 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg               <= S_IDLE;
            level_reg               <= '0;
            path_reg                <= '0;
            element_is_triangle_reg <= 1'b0;
            cnt_reg                 <= '0;
            fault_reg               <= FAULT_OK;
            done_reg                <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            path_reg  <= path_next;
            cnt_reg   <= cnt_next;
            fault_reg <= fault_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                element_is_triangle_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        child_reg <= child_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
        if (digit_we)
        begin
            digit_reg[cnt_reg] <= idx_dec[2:0];
        end
    end

    // Checks
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_MAX)
        else $error("stack level above maximum");

    a_no_write_entry0: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ram_waddr != '0))
        else $error("write to identity entry");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_PUSH || $past(state_reg) == S_SHOW))
        else $error("result strobe without finishing state");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result shown while busy");

    a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.fault == FAULT_EMPTY) |-> (res_reg.level == '0))
        else $error("empty fault with nonzero level");

endmodule

// ----- tb/tb_refinement_transform_stack.sv -----
// ----------------------------------------------------------------------------
// tb_refinement_transform_stack
// Self-checking bench for the refinement transform stack. Requests are pushed
// through the start/busy handshake with random gaps; a built-in stack model
// predicts the top transform, depth, path and fault of each request, and
// every done strobe is compared field by field with the oldest prediction.
// Directed tests cover the empty and full stack, every child of both tables
// and the set corner cases; random walks then run under both table selects.
// ----------------------------------------------------------------------------
module tb_refinement_transform_stack;

    timeunit 1ns;
    timeprecision 1ps;

    import rts_pkg::*;

    localparam int DEPTH_MAX  = MAX_LEVEL_DEF;
    localparam int CYCLE_CAP  = 600000;
    localparam logic [PATH_W-1:0] PATH_DEEPEST_OK = 46'd40210710958664;

    // Affine map of one stack entry, kept wider than the ports
    typedef struct {
        longint sx;
        longint sy;
        longint ox;
        longint oy;
    } map_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    req_t               req       = '0;
    logic               done;
    rsp_t               res;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data  = 1'b0;

    // Model state
    map_t               maps [0:DEPTH_MAX];
    int                 depth;
    logic [PATH_W-1:0]  path_reg;
    bit                 tri_sel;

    rsp_t               tops_due [$];
    rsp_t               seen_top;
    int                 fails     = 0;
    int                 cycles    = 0;
    int                 calm_run  = 0;

    refinement_transform_stack uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stack model
    // ------------------------------------------------------------------

    // Parent scale times 1, 1/2, -1/2 or 0; halving floors
    function automatic longint scaled(input longint v, input factor_t f);
        begin
            case (f)
                FACT_ONE:   return v;
                FACT_HALF:  return v >>> 1;
                FACT_NHALF: return (-v) >>> 1;
                default:    return 0;
            endcase
        end
    endfunction

    function automatic void clear_stack();
        begin
            maps[0].sx = longint'(1) << FRAC_BITS_DEF;
            maps[0].sy = longint'(1) << FRAC_BITS_DEF;
            maps[0].ox = 0;
            maps[0].oy = 0;
            depth      = 0;
            path_reg   = '0;
        end
    endfunction

    // Compose the top with one son; 0 when the stack is already full
    function automatic bit push_son(input logic [CHILD_W-1:0] son);
        child_row_t         row;
        map_t               cur;
        logic [CHILD_W-1:0] c;
        begin
            c = (son > CHILD_IDENTITY) ? CHILD_IDENTITY : son;
            if (depth >= DEPTH_MAX)
                return 1'b0;
            row = IDENT_ROW;
            if (tri_sel)
            begin
                case (c)
                    4'd0: row = '{FACT_HALF,  FACT_HALF,  FACT_NHALF, FACT_NHALF};
                    4'd1: row = '{FACT_HALF,  FACT_HALF,  FACT_HALF,  FACT_NHALF};
                    4'd2: row = '{FACT_HALF,  FACT_HALF,  FACT_NHALF, FACT_HALF};
                    4'd3: row = '{FACT_NHALF, FACT_NHALF, FACT_NHALF, FACT_NHALF};
                    default: row = IDENT_ROW;
                endcase
            end
            else
            begin
                case (c)
                    4'd0: row = '{FACT_HALF, FACT_HALF, FACT_NHALF, FACT_NHALF};
                    4'd1: row = '{FACT_HALF, FACT_HALF, FACT_HALF,  FACT_NHALF};
                    4'd2: row = '{FACT_HALF, FACT_HALF, FACT_HALF,  FACT_HALF};
                    4'd3: row = '{FACT_HALF, FACT_HALF, FACT_NHALF, FACT_HALF};
                    4'd4: row = '{FACT_ONE,  FACT_HALF, FACT_ZERO,  FACT_NHALF};
                    4'd5: row = '{FACT_ONE,  FACT_HALF, FACT_ZERO,  FACT_HALF};
                    4'd6: row = '{FACT_HALF, FACT_ONE,  FACT_NHALF, FACT_ZERO};
                    4'd7: row = '{FACT_HALF, FACT_ONE,  FACT_HALF,  FACT_ZERO};
                    default: row = IDENT_ROW;
                endcase
            end
            cur = maps[depth];
            maps[depth + 1].sx = scaled(cur.sx, row.sx);
            maps[depth + 1].sy = scaled(cur.sy, row.sy);
            maps[depth + 1].ox = scaled(cur.sx, row.ox) + cur.ox;
            maps[depth + 1].oy = scaled(cur.sy, row.oy) + cur.oy;
            depth++;
            // digit is child+1; identity's 9 carries, path wraps at 46 bits
            path_reg = {path_reg[PATH_W-4:0], 3'b000} + PATH_W'(c) + 46'd1;
            return 1'b1;
        end
    endfunction

    // Apply one request to the model and return the expected result
    function automatic rsp_t stack_after(input req_t r);
        rsp_t               o;
        logic [PATH_W-1:0]  rest;
        logic [CHILD_W-1:0] digs [0:23];
        int                 n;
        begin
            o.fault = FAULT_OK;
            case (r.mode)
                MODE_PUSH:
                begin
                    if (!push_son(r.child))
                        o.fault = FAULT_TOO_DEEP;
                end
                MODE_POP:
                begin
                    if (depth == 0)
                        o.fault = FAULT_EMPTY;
                    else
                    begin
                        depth--;
                        path_reg = (path_reg - 46'd1) >> 3;
                    end
                end
                MODE_SET:
                begin
                    // decode least significant digit first
                    n    = 0;
                    rest = r.path_in;
                    while (rest != '0 && n < 24)
                    begin
                        digs[n] = {1'b0, 3'(rest - 46'd1)};
                        rest    = (rest - 46'd1) >> 3;
                        n++;
                    end
                    clear_stack();
                    if (n > DEPTH_MAX)
                        o.fault = FAULT_TOO_DEEP;
                    else
                    begin
                        while (n > 0)
                        begin
                            n--;
                            void'(push_son(digs[n]));
                        end
                    end
                end
                default:
                    clear_stack();
            endcase
            o.scale_x  = 32'(maps[depth].sx);
            o.scale_y  = 32'(maps[depth].sy);
            o.offset_x = 32'(maps[depth].ox);
            o.offset_y = 32'(maps[depth].oy);
            o.level    = LEVEL_W'(depth);
            o.path_out = path_reg;
            return o;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        begin
            if (got !== want)
            begin
                fails++;
                $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (tops_due.size() == 0)
            begin
                fails++;
                $display("%0t ns: result with no request outstanding, actual %0h",
                         $time, res);
            end
            else
            begin
                seen_top = tops_due.pop_front();
                check_field("scale_x",  64'(seen_top.scale_x),  64'(res.scale_x));
                check_field("scale_y",  64'(seen_top.scale_y),  64'(res.scale_y));
                check_field("offset_x", 64'(seen_top.offset_x), 64'(res.offset_x));
                check_field("offset_y", 64'(seen_top.offset_y), 64'(res.offset_y));
                check_field("level",    64'(seen_top.level),    64'(res.level));
                check_field("path_out", 64'(seen_top.path_out), 64'(res.path_out));
                check_field("fault",    64'(seen_top.fault),    64'(res.fault));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic req_t make_req(input logic [MODE_W-1:0] m,
                                      input logic [CHILD_W-1:0] c,
                                      input logic [PATH_W-1:0] p);
        req_t r;
        begin
            r.mode    = m;
            r.child   = c;
            r.path_in = p;
            return r;
        end
    endfunction

    function automatic logic [PATH_W-1:0] rand_path();
        begin
            return PATH_W'({$urandom, $urandom});
        end
    endfunction

    // Path of n random sons in 0..hi, outermost first
    function automatic logic [PATH_W-1:0] path_from_children(input int n, input int hi);
        logic [PATH_W-1:0] p;
        begin
            p = '0;
            repeat (n)
                p = {p[PATH_W-4:0], 3'b000} + PATH_W'($urandom_range(0, hi)) + 46'd1;
            return p;
        end
    endfunction

    // One request: random hold-off, then wait for the block to take it
    task automatic send_request(input req_t r);
        int gap;
        begin
            if (calm_run > 0)
            begin
                gap = 0;
                calm_run--;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                gap      = 0;
                calm_run = $urandom_range(5, 30);
            end
            else
                gap = $urandom_range(0, 10);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start <= 1'b1;
            req   <= r;
            do
                @(posedge clk);
            while (busy);
            tops_due.push_back(stack_after(r));
        end
    endtask

    // Table select write, only once all results are in
    task automatic write_table(input bit is_tri);
        begin
            start <= 1'b0;
            while (tops_due.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= is_tri;
            do
                @(posedge clk);
            while (!cfg_ready);
            tri_sel = is_tri;
            cfg_valid <= 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Pop on an empty stack, then a plain reset request
    task automatic test_empty_stack();
        begin
            write_table(1'b0);
            send_request(make_req(MODE_POP, 4'd0, '0));
            send_request(make_req(MODE_RESET, 4'd15, '1));
        end
    endtask

    // Every quad son, the identity child and a child above eight
    task automatic test_quad_children();
        begin
            for (int c = 0; c <= 8; c++)
                send_request(make_req(MODE_PUSH, CHILD_W'(c), rand_path()));
            send_request(make_req(MODE_PUSH, 4'd15, '1));
        end
    endtask

    // Deepest legal set, push when full, pop, too-deep set and set with zero
    task automatic test_set_paths();
        begin
            send_request(make_req(MODE_SET, 4'd0, PATH_DEEPEST_OK));
            send_request(make_req(MODE_PUSH, 4'd0, '0));
            send_request(make_req(MODE_POP, 4'd15, '0));
            send_request(make_req(MODE_SET, 4'd0, '1));
            send_request(make_req(MODE_SET, 4'd0, '0));
        end
    endtask

    // Triangle sons, including the mirrored one, a short set and two pops
    task automatic test_triangle_children();
        begin
            write_table(1'b1);
            for (int c = 0; c <= 4; c++)
                send_request(make_req(MODE_PUSH, CHILD_W'(c), rand_path()));
            send_request(make_req(MODE_SET, 4'd0, path_from_children(5, 3)));
            send_request(make_req(MODE_POP, 4'd0, rand_path()));
            send_request(make_req(MODE_POP, 4'd0, rand_path()));
        end
    endtask

    // Random walk: mostly pushes and pops, with sets and resets mixed in
    task automatic test_random_walk(input int count, input bit is_tri);
        req_t r;
        int   pick;
        int   hi;
        begin
            write_table(is_tri);
            for (int i = 0; i < count; i++)
            begin
                r.path_in = rand_path();
                r.child   = ($urandom_range(0, 9) < 7) ? CHILD_W'($urandom_range(0, 7))
                                                       : CHILD_W'($urandom_range(0, 15));
                pick = $urandom_range(0, 99);
                if (pick < 52)
                    r.mode = MODE_PUSH;
                else if (pick < 78)
                    r.mode = MODE_POP;
                else if (pick < 95)
                begin
                    r.mode = MODE_SET;
                    pick   = $urandom_range(0, 99);
                    hi     = ($urandom_range(0, 4) == 0) ? 8 : (is_tri ? 3 : 7);
                    if (pick < 70)
                        r.path_in = path_from_children($urandom_range(0, DEPTH_MAX), hi);
                    else if (pick < 80)
                        r.path_in = path_from_children(DEPTH_MAX + 1, 0);
                end
                else
                    r.mode = MODE_RESET;
                send_request(r);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        for (int i = 0; i <= DEPTH_MAX; i++)
            maps[i] = '{0, 0, 0, 0};
        clear_stack();
        tri_sel = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_quad_children();
        test_set_paths();
        test_triangle_children();
        for (int ph = 0; ph < 6; ph++)
            test_random_walk(312, ph[0]);

        // drain
        start <= 1'b0;
        while (tops_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/rts_pkg.sv
rtl/core/rts_ram.sv
rtl/core/rts_compose.sv
rtl/core/refinement_transform_stack.sv
tb/tb_refinement_transform_stack.sv
